[src/pbt_pkg.sv]
// Shared types, constants and step functions of the brick texture pipeline.
package pbt_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned RDIV_STEPS  = 31;
  localparam int unsigned FMOD_STEPS  = 32;
  localparam int unsigned BDIV_STEPS  = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] HASH_MUL_C = 32'd60493;
  localparam logic [31:0] HASH_ADD_A = 32'd19990303;
  localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
  localparam logic [16:0] TINT_ONE   = 17'd65536;

  typedef enum logic [2:0] {
    REG_BRICK_WIDTH      = 3'd0,
    REG_ROW_HEIGHT       = 3'd1,
    REG_MORTAR_THICKNESS = 3'd2,
    REG_TINT_BIAS        = 3'd3,
    REG_OFFSET_AMOUNT    = 3'd4,
    REG_SQUASH_AMOUNT    = 3'd5,
    REG_OFFSET_FREQUENCY = 3'd6,
    REG_SQUASH_FREQUENCY = 3'd7
  } pbt_reg_e;

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [31:0]        brick_color_a;
    logic [31:0]        brick_color_b;
    logic [31:0]        mortar_color;
  } pbt_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       in_mortar;
  } pbt_out_t;

  // Register values as the datapath sees them (zero sizes already raised)
  typedef struct packed {
    logic [22:0]        brick_w;
    logic [22:0]        row_h;
    logic [16:0]        th;
    logic signed [17:0] bias;
    logic [16:0]        off_amt;
    logic [22:0]        sq_amt;
    logic [6:0]         off_freq;
    logic [6:0]         sq_freq;
  } pbt_cfg_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] m;
  } pbt_col_t;

  typedef struct packed {
    logic [31:0] x;
    pbt_col_t    col;
    logic        neg;
    logic [22:0] rem;
    logic [30:0] qd;
  } pbt_rdiv_t;

  typedef struct packed {
    logic [31:0] x;
    pbt_col_t    col;
    logic [31:0] row;
    logic [22:0] iy;
    logic [31:0] mag;
    logic [6:0]  rs;
    logic [6:0]  ro;
  } pbt_fmod_t;

  typedef struct packed {
    logic [31:0] x;
    pbt_col_t    col;
    logic [15:0] row_lo;
    logic [22:0] iy;
    logic [29:0] w;
    logic        ofs;
  } pbt_sq_t;

  typedef struct packed {
    logic [31:0] x;
    pbt_col_t    col;
    logic [15:0] row_lo;
    logic [22:0] iy;
    logic [29:0] w;
    logic [30:0] off;
  } pbt_mid_t;

  typedef struct packed {
    pbt_col_t    col;
    logic [15:0] row_lo;
    logic [22:0] iy;
    logic [29:0] w;
    logic        neg;
    logic [29:0] rem;
    logic [31:0] qd;
  } pbt_bdiv_t;

  typedef struct packed {
    pbt_col_t    col;
    logic [31:0] n;
    logic [31:0] acc;
    logic [16:0] t;
    logic        mortar;
  } pbt_tail_t;

  // One restoring step of the row division
  function automatic pbt_rdiv_t rdiv_step(pbt_rdiv_t s, logic [22:0] d);
    pbt_rdiv_t   o;
    logic [23:0] r2;
    o  = s;
    r2 = {s.rem, s.qd[30]};
    if (r2 >= {1'b0, d}) begin
      o.rem = 23'(r2 - {1'b0, d});
      o.qd  = {s.qd[29:0], 1'b1};
    end else begin
      o.rem = r2[22:0];
      o.qd  = {s.qd[29:0], 1'b0};
    end
    return o;
  endfunction

  // One remainder step for both row frequencies
  function automatic pbt_fmod_t fmod_step(pbt_fmod_t s, logic [6:0] fs, logic [6:0] fo);
    pbt_fmod_t  o;
    logic [7:0] r2s;
    logic [7:0] r2o;
    o   = s;
    r2s = {s.rs, s.mag[31]};
    r2o = {s.ro, s.mag[31]};
    if (r2s >= {1'b0, fs}) o.rs = 7'(r2s - {1'b0, fs});
    else                   o.rs = r2s[6:0];
    if (r2o >= {1'b0, fo}) o.ro = 7'(r2o - {1'b0, fo});
    else                   o.ro = r2o[6:0];
    o.mag = {s.mag[30:0], 1'b0};
    return o;
  endfunction

  // One restoring step of the brick division
  function automatic pbt_bdiv_t bdiv_step(pbt_bdiv_t s);
    pbt_bdiv_t   o;
    logic [30:0] r2;
    o  = s;
    r2 = {s.rem, s.qd[31]};
    if (r2 >= {1'b0, s.w}) begin
      o.rem = 30'(r2 - {1'b0, s.w});
      o.qd  = {s.qd[30:0], 1'b1};
    end else begin
      o.rem = r2[29:0];
      o.qd  = {s.qd[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[src/pbt_front.sv]
// Front part: row division, row classification and brick width / offset.
module pbt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pbt_pkg::pbt_cfg_t  cfg_i,
  input  logic               in_valid_i,
  input  pbt_pkg::pbt_in_t   in_data_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output pbt_pkg::pbt_mid_t  out_data_o,
  input  logic               out_ready_i
);

  localparam int unsigned RN = pbt_pkg::RDIV_STEPS;
  localparam int unsigned FN = pbt_pkg::FMOD_STEPS;

  logic adv;
  logic take;

  pbt_pkg::pbt_rdiv_t rdiv_q [RN+1];
  pbt_pkg::pbt_fmod_t fmod_q [FN+1];
  pbt_pkg::pbt_fmod_t fmod_d;
  pbt_pkg::pbt_rdiv_t rdiv_d;
  pbt_pkg::pbt_sq_t   sq_q, sq_d;
  pbt_pkg::pbt_mid_t  off_q, off_d;

  logic [RN:0] rv_q;
  logic [FN:0] fv_q;
  logic        sv_q;
  logic        ov_q;

  logic [45:0] wprod;
  logic [29:0] wsq;
  logic [46:0] oprod;
  logic        both_en;

  assign adv        = out_ready_i;
  assign in_ready_o = adv;
  assign take       = in_valid_i & adv;

  // Fold a negative y onto its complement so the divider sees a positive value
  always_comb begin
    rdiv_d.x   = in_data_i.coord_x;
    rdiv_d.col = '{a: in_data_i.brick_color_a, b: in_data_i.brick_color_b,
                   m: in_data_i.mortar_color};
    rdiv_d.neg = in_data_i.coord_y[31];
    rdiv_d.rem = '0;
    rdiv_d.qd  = in_data_i.coord_y[31] ? ~in_data_i.coord_y[30:0] : in_data_i.coord_y[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) rdiv_q[0] <= rdiv_d;
  end

  for (genvar k = 0; k < RN; k++) begin : g_rdiv
    always_ff @(posedge clk_i) begin
      if (adv) rdiv_q[k+1] <= pbt_pkg::rdiv_step(rdiv_q[k], cfg_i.row_h);
    end
  end

  // Undo the fold: floor quotient, remainder and magnitude for the row tests
  always_comb begin
    fmod_d.x   = rdiv_q[RN].x;
    fmod_d.col = rdiv_q[RN].col;
    if (rdiv_q[RN].neg) begin
      fmod_d.row = ~{1'b0, rdiv_q[RN].qd};
      fmod_d.mag = {1'b0, rdiv_q[RN].qd} + 32'd1;
      fmod_d.iy  = 23'(cfg_i.row_h - 23'd1 - rdiv_q[RN].rem);
    end else begin
      fmod_d.row = {1'b0, rdiv_q[RN].qd};
      fmod_d.mag = {1'b0, rdiv_q[RN].qd};
      fmod_d.iy  = rdiv_q[RN].rem;
    end
    fmod_d.rs = '0;
    fmod_d.ro = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) fmod_q[0] <= fmod_d;
  end

  for (genvar k = 0; k < FN; k++) begin : g_fmod
    always_ff @(posedge clk_i) begin
      if (adv) fmod_q[k+1] <= pbt_pkg::fmod_step(fmod_q[k], cfg_i.sq_freq, cfg_i.off_freq);
    end
  end

  // Classify the row and pick the brick width
  always_comb begin
    both_en  = (cfg_i.off_freq != '0) && (cfg_i.sq_freq != '0);
    wprod    = {23'b0, cfg_i.brick_w} * {23'b0, cfg_i.sq_amt};
    wsq      = wprod[45:16];
    sq_d.x      = fmod_q[FN].x;
    sq_d.col    = fmod_q[FN].col;
    sq_d.row_lo = fmod_q[FN].row[15:0];
    sq_d.iy     = fmod_q[FN].iy;
    sq_d.ofs    = both_en && (fmod_q[FN].ro == '0);
    if (both_en && (fmod_q[FN].rs == '0)) begin
      sq_d.w = (wsq == '0) ? 30'd1 : wsq;
    end else begin
      sq_d.w = {7'b0, cfg_i.brick_w};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) sq_q <= sq_d;
  end

  // Shift of offset rows
  always_comb begin
    oprod        = {17'b0, sq_q.w} * {30'b0, cfg_i.off_amt};
    off_d.x      = sq_q.x;
    off_d.col    = sq_q.col;
    off_d.row_lo = sq_q.row_lo;
    off_d.iy     = sq_q.iy;
    off_d.w      = sq_q.w;
    off_d.off    = sq_q.ofs ? oprod[46:16] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) off_q <= off_d;
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= '0;
      fv_q <= '0;
      sv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      rv_q <= {rv_q[RN-1:0], take};
      fv_q <= {fv_q[FN-1:0], rv_q[RN]};
      sv_q <= fv_q[FN];
      ov_q <= sv_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = off_q;

endmodule

[src/pbt_mid_queue.sv]
// Short queue between the front and the back part.
module pbt_mid_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pbt_pkg::pbt_mid_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output pbt_pkg::pbt_mid_t rdata_o,
  output logic              empty_o
);

  localparam int unsigned D = pbt_pkg::QUEUE_DEPTH;

  pbt_pkg::pbt_mid_t     mem_q [D];
  logic [$clog2(D)-1:0]  wp_q, rp_q;
  logic [$clog2(D):0]    cnt_q;

  assign full_o  = (cnt_q == ($clog2(D)+1)'(D));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  // Move the pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[src/pbt_back.sv]
// Back part: brick division, hash, tint, colour mix and result queue.
module pbt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pbt_pkg::pbt_cfg_t cfg_i,
  input  logic              in_valid_i,
  input  pbt_pkg::pbt_mid_t in_data_i,
  output logic              in_take_o,
  output pbt_pkg::pbt_out_t out_data_o,
  output logic              empty_o,
  input  logic              pop_i
);

  localparam int unsigned BN = pbt_pkg::BDIV_STEPS;
  localparam int unsigned D  = pbt_pkg::QUEUE_DEPTH;

  logic adv;
  logic take;

  pbt_pkg::pbt_bdiv_t bdiv_q [BN+1];
  pbt_pkg::pbt_bdiv_t bdiv_d;
  pbt_pkg::pbt_tail_t tl_q [5];
  pbt_pkg::pbt_tail_t tl_d [5];
  logic [BN:0]        bv_q;
  logic [4:0]         tv_q;

  logic [33:0]        xs;
  logic [15:0]        brick_lo;
  logic [29:0]        ix;
  logic [31:0]        n0;
  logic signed [31:0] ixs, iys, ths, wlim, hlim;
  logic [63:0]        m1, m2, m3;
  logic signed [18:0] tsum;

  pbt_pkg::pbt_out_t  res;
  logic [16:0]        tinv;
  logic [25:0]        mix [3];

  pbt_pkg::pbt_out_t     oq_q [D];
  logic [$clog2(D)-1:0]  owp_q, orp_q;
  logic [$clog2(D):0]    ocnt_q;
  logic                  opush, opop;

  assign adv       = (ocnt_q != ($clog2(D)+1)'(D));
  assign take      = in_valid_i & adv;
  assign in_take_o = take;

  // Shifted x, folded onto a positive value for the divider
  always_comb begin
    xs            = {{2{in_data_i.x[31]}}, in_data_i.x} + {3'b0, in_data_i.off};
    bdiv_d.col    = in_data_i.col;
    bdiv_d.row_lo = in_data_i.row_lo;
    bdiv_d.iy     = in_data_i.iy;
    bdiv_d.w      = in_data_i.w;
    bdiv_d.neg    = xs[33];
    bdiv_d.rem    = '0;
    bdiv_d.qd     = xs[33] ? ~xs[31:0] : xs[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) bdiv_q[0] <= bdiv_d;
  end

  for (genvar k = 0; k < BN; k++) begin : g_bdiv
    always_ff @(posedge clk_i) begin
      if (adv) bdiv_q[k+1] <= pbt_pkg::bdiv_step(bdiv_q[k]);
    end
  end

  // Brick index, position in the brick, mortar test and hash seed
  always_comb begin
    if (bdiv_q[BN].neg) begin
      brick_lo = ~bdiv_q[BN].qd[15:0];
      ix       = 30'(bdiv_q[BN].w - 30'd1 - bdiv_q[BN].rem);
    end else begin
      brick_lo = bdiv_q[BN].qd[15:0];
      ix       = bdiv_q[BN].rem;
    end
    n0   = {bdiv_q[BN].row_lo, brick_lo};
    ixs  = signed'({2'b0, ix});
    iys  = signed'({9'b0, bdiv_q[BN].iy});
    ths  = signed'({15'b0, cfg_i.th});
    wlim = signed'({2'b0, bdiv_q[BN].w}) - ths;
    hlim = signed'({9'b0, cfg_i.row_h}) - ths;
    tl_d[0].col    = bdiv_q[BN].col;
    tl_d[0].n      = n0 ^ {{13{n0[31]}}, n0[31:13]};
    tl_d[0].acc    = '0;
    tl_d[0].t      = '0;
    tl_d[0].mortar = (ixs < ths) || (iys < ths) || (ixs > wlim) || (iys > hlim);
  end

  // Hash polynomial, one multiplication per stage
  always_comb begin
    m1 = {32'b0, tl_q[0].n} * {32'b0, tl_q[0].n};
    tl_d[1]     = tl_q[0];
    tl_d[1].acc = m1[31:0];
    m2 = {32'b0, tl_q[1].acc} * {32'b0, pbt_pkg::HASH_MUL_C};
    tl_d[2]     = tl_q[1];
    tl_d[2].acc = m2[31:0] + pbt_pkg::HASH_ADD_A;
    m3 = {32'b0, tl_q[2].n} * {32'b0, tl_q[2].acc};
    tl_d[3]     = tl_q[2];
    tl_d[3].acc = m3[31:0] + pbt_pkg::HASH_ADD_B;
  end

  // Tint: top hash bits plus bias, clamped to the unit range
  always_comb begin
    tsum = signed'({3'b0, tl_q[3].acc[30:15]}) + {cfg_i.bias[17], cfg_i.bias};
    tl_d[4] = tl_q[3];
    if (tsum < 0)                                  tl_d[4].t = '0;
    else if (tsum > signed'({2'b0, pbt_pkg::TINT_ONE})) tl_d[4].t = pbt_pkg::TINT_ONE;
    else                                           tl_d[4].t = tsum[16:0];
  end

  for (genvar k = 0; k < 5; k++) begin : g_tail
    always_ff @(posedge clk_i) begin
      if (adv) tl_q[k] <= tl_d[k];
    end
  end

  // Mix the brick colours, or pass the mortar colour
  always_comb begin
    tinv = pbt_pkg::TINT_ONE - tl_q[4].t;
    for (int k = 0; k < 3; k++) begin
      mix[k] = {18'b0, tl_q[4].col.a[31-8*k -: 8]} * {9'b0, tinv}
             + {18'b0, tl_q[4].col.b[31-8*k -: 8]} * {9'b0, tl_q[4].t}
             + 26'd32768;
    end
    if (tl_q[4].mortar) begin
      res.red   = tl_q[4].col.m[31:24];
      res.green = tl_q[4].col.m[23:16];
      res.blue  = tl_q[4].col.m[15:8];
      res.alpha = tl_q[4].col.m[7:0];
    end else begin
      res.red   = mix[0][23:16];
      res.green = mix[1][23:16];
      res.blue  = mix[2][23:16];
      res.alpha = tl_q[4].col.a[7:0];
    end
    res.in_mortar = tl_q[4].mortar;
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
      tv_q <= '0;
    end else if (adv) begin
      bv_q <= {bv_q[BN-1:0], take};
      tv_q <= {tv_q[3:0], bv_q[BN]};
    end
  end

  // Result queue
  assign opush      = tv_q[4] & adv;
  assign empty_o    = (ocnt_q == '0);
  assign opop       = pop_i & ~empty_o;
  assign out_data_o = oq_q[orp_q];

  always_ff @(posedge clk_i) begin
    if (opush) oq_q[owp_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (opush) owp_q <= owp_q + 1'b1;
      if (opop)  orp_q <= orp_q + 1'b1;
      if (opush && !opop)      ocnt_q <= ocnt_q + 1'b1;
      else if (opop && !opush) ocnt_q <= ocnt_q - 1'b1;
    end
  end

endmodule

[src/procedural_brick_texture_top.sv]
// Brick texture evaluator: configuration registers and the front/back pipeline.
//
// Each item is a Q16.16 point with three RGBA8 colours; each result is the
// texel colour and a mortar flag. One item is taken per clock while results
// drain. After it is taken, an item passes through 1 input stage, 31 stages
// of the row divider, 1 + 32 stages of the row-frequency remainder, 2 stages
// for brick width and shift, the middle queue, 1 + 32 stages of the brick
// divider and 5 hash/tint stages, then is written into the 4-entry result
// queue. Both dividers resolve one quotient bit per stage. Registers may be
// written only while the block is empty.
module procedural_brick_texture_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [22:0]       cfg_wdata_i,
  input  logic              push,
  input  pbt_pkg::pbt_in_t  in_data_i,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output pbt_pkg::pbt_out_t out_data_o
);

  logic [22:0] brick_w_q, row_h_q, sq_amt_q;
  logic [16:0] th_q, off_amt_q;
  logic [17:0] bias_q;
  logic [6:0]  off_freq_q, sq_freq_q;

  pbt_pkg::pbt_cfg_t cfg;
  logic              f_ready, f_valid;
  pbt_pkg::pbt_mid_t f_data, q_data;
  logic              q_full, q_empty, b_take;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brick_w_q  <= 23'd32768;
      row_h_q    <= 23'd16384;
      th_q       <= 17'd1311;
      bias_q     <= '0;
      off_amt_q  <= 17'd32768;
      sq_amt_q   <= 23'd65536;
      off_freq_q <= '0;
      sq_freq_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (pbt_pkg::pbt_reg_e'(cfg_idx_i))
        pbt_pkg::REG_BRICK_WIDTH:      brick_w_q  <= cfg_wdata_i;
        pbt_pkg::REG_ROW_HEIGHT:       row_h_q    <= cfg_wdata_i;
        pbt_pkg::REG_MORTAR_THICKNESS: th_q       <= cfg_wdata_i[16:0];
        pbt_pkg::REG_TINT_BIAS:        bias_q     <= cfg_wdata_i[17:0];
        pbt_pkg::REG_OFFSET_AMOUNT:    off_amt_q  <= cfg_wdata_i[16:0];
        pbt_pkg::REG_SQUASH_AMOUNT:    sq_amt_q   <= cfg_wdata_i;
        pbt_pkg::REG_OFFSET_FREQUENCY: off_freq_q <= cfg_wdata_i[6:0];
        pbt_pkg::REG_SQUASH_FREQUENCY: sq_freq_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Raise zero sizes to one LSB
  always_comb begin
    cfg.brick_w  = (brick_w_q == '0) ? 23'd1 : brick_w_q;
    cfg.row_h    = (row_h_q == '0) ? 23'd1 : row_h_q;
    cfg.th       = th_q;
    cfg.bias     = signed'(bias_q);
    cfg.off_amt  = off_amt_q;
    cfg.sq_amt   = sq_amt_q;
    cfg.off_freq = off_freq_q;
    cfg.sq_freq  = sq_freq_q;
  end

  assign full = ~f_ready;

  pbt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (push),
    .in_data_i   (in_data_i),
    .in_ready_o  (f_ready),
    .out_valid_o (f_valid),
    .out_data_o  (f_data),
    .out_ready_i (~q_full)
  );

  pbt_mid_queue u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid & ~q_full),
    .wdata_i (f_data),
    .full_o  (q_full),
    .pop_i   (b_take),
    .rdata_o (q_data),
    .empty_o (q_empty)
  );

  pbt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (~q_empty),
    .in_data_i  (q_data),
    .in_take_o  (b_take),
    .out_data_o (out_data_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

endmodule
